FILE: sv/four_digit_seven_segment_encoder_defines.svh
// Assertion macros shared by the display encoder RTL.
// Depends on nothing; included by the top level only.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSEG_ASSERT_IMPL(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSEG_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: sv/sseg_pkg.sv
// Shared types, codes, glyph tables and helper functions for the display encoder.
// Depends on nothing; used by sseg_digits, sseg_frames and the top level.
package sseg_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_NUMBER  = 2'd0;
    localparam logic [1:0] OP_FLIPPED = 2'd1;
    localparam logic [1:0] OP_LETTERS = 2'd2;

    // Register byte address of the night mode bit.
    localparam logic [1:0] ADDR_NIGHT_MODE = 2'd0;

    localparam logic [13:0] NUMBER_MAX = 14'd9999;
    localparam logic [13:0] WEIGHT_THOUSANDS = 14'd1000;
    localparam logic [13:0] WEIGHT_HUNDREDS  = 14'd100;
    localparam logic [13:0] WEIGHT_TENS      = 14'd10;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_FIRST = 8'd65;
    localparam logic [7:0] CHAR_LAST  = 8'd90;

    localparam logic [7:0] ALPHA_GLYPH [26] = '{
        8'h77, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h04, 8'h0E, 8'h70,
        8'h38, 8'h23, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h72,
        8'h4F, 8'h76, 8'h66, 8'h49
    };

    // One request as taken from the input channel. Character 0 is the rightmost.
    typedef struct packed {
        logic [1:0]       op;
        logic [13:0]      number;
        logic [3:0]       dots;
        logic [3:0][7:0]  chars;
    } req_t;

    // Request on its way through the digit pipeline. Digit 0 is the units digit.
    typedef struct packed {
        logic [1:0]       op;
        logic [3:0]       dots;
        logic [3:0][7:0]  chars;
        logic             over;
        logic [3:0][3:0]  digits;
        logic [9:0]       rem;
    } pipe_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rem;
    } dec_t;

    typedef struct packed {
        logic       bad;
        logic [7:0] glyph;
    } char_t;

    // One decimal digit off the top of a value below ten times the weight.
    function automatic dec_t dec_step(input logic [13:0] value, input logic [13:0] weight);
        dec_t        r;
        logic [13:0] base;
        r.digit = '0;
        base    = '0;
        for (int k = 1; k < 10; k++) begin
            if (value >= 14'(k) * weight) begin
                r.digit = 4'(k);
                base    = 14'(k) * weight;
            end
        end
        r.rem = value - base;
        return r;
    endfunction

    // Glyph of a decimal digit, upright or turned upside down.
    function automatic logic [7:0] num_glyph(input logic [3:0] d, input logic flip);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = flip ? 8'h30 : 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = flip ? 8'h79 : 8'h4F;
            4'd4:    g = flip ? 8'h74 : 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = flip ? 8'h67 : 8'h7C;
            4'd7:    g = flip ? 8'h38 : 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = flip ? 8'h7C : 8'h67;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Glyph of a letter or a space; anything else is blank and flagged.
    function automatic char_t char_glyph(input logic [7:0] c);
        char_t r;
        r.bad   = 1'b0;
        r.glyph = 8'h00;
        if (c == CHAR_SPACE) begin
            r.glyph = 8'h00;
        end else if (c >= CHAR_FIRST && c <= CHAR_LAST) begin
            r.glyph = ALPHA_GLYPH[5'(c - CHAR_FIRST)];
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // Reorder glyph bits A..G,DP into the shift-register pin order.
    function automatic logic [7:0] to_pins(input logic [7:0] g);
        return {g[6], g[2], g[7], g[3], g[4], g[1], g[5], g[0]};
    endfunction

endpackage

FILE: sv/four_digit_seven_segment_encoder.sv
// Four-digit seven-segment encoder: each request item becomes four display frames
// that carry a segment byte in shift-register pin order, the digit position, a dim
// flag, a bad-input flag and a last mark. Frames come out units first: the units
// digit (or the rightmost letter) leads and the thousands digit (or leftmost letter)
// closes the item with last set. Op 0 shows a number 0..9999 with leading zeros
// blanked and decimal points from dot_mask; op 1 shows it with the upside-down
// glyph set at mirrored positions; op 2 shows four letters A..Z or space. Numbers
// above 9999 show as 9999 and letters outside the set show blank, with bad_input
// set on all four frames; op 3 gives four blank frames with bad_input set. The
// output port emits one frame per cycle while m_ready is high; an accepted item
// passes the input register, three decimal digit stages and the frame buffer
// before its first frame is on the output. The input is taken while the frame
// buffer still drains, so a following item waits in the pipeline and its frames
// follow without a gap. The night_mode register (byte address 0 of the register
// port) is copied into dim and should only be written while idle.
// Depends on sseg_pkg, sseg_digits, sseg_frames and the assertion macro header.
`include "four_digit_seven_segment_encoder_defines.svh"

module four_digit_seven_segment_encoder (
    input  logic        aclk,
    input  logic        aresetn,

    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Request channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [13:0] s_number,
    input  logic [3:0]  s_dot_mask,
    input  logic [7:0]  s_char_left,
    input  logic [7:0]  s_char_second,
    input  logic [7:0]  s_char_third,
    input  logic [7:0]  s_char_right,

    // Frame channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_segments,
    output logic [1:0]  m_position,
    output logic        m_dim,
    output logic        m_bad_input,
    output logic        m_last
);

    logic            night_mode_reg;
    logic            night_mode_next;
    logic            in_valid_reg;
    sseg_pkg::req_t  in_reg;
    sseg_pkg::req_t  in_next;
    logic            dig_ready;
    logic            dig_valid;
    sseg_pkg::pipe_t dig_pipe;
    logic            frm_ready;
    logic            frame_take;
    logic            last_frame;
    logic            last_pos_ok;

    // The register port never stalls. A write lands in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == sseg_pkg::ADDR_NIGHT_MODE) ? {31'd0, night_mode_reg} : 32'd0;

    always_comb begin
        night_mode_next = night_mode_reg;
        if (psel && penable && pwrite && paddr == sseg_pkg::ADDR_NIGHT_MODE) begin
            night_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            night_mode_reg <= 1'b0;
        end else begin
            night_mode_reg <= night_mode_next;
        end
    end

    // Input register. It accepts a new item whenever its content moves on,
    // so the request side never waits on an idle block.
    assign s_ready = !in_valid_reg || dig_ready;

    always_comb begin
        in_next.op       = s_op;
        in_next.number   = s_number;
        in_next.dots     = s_dot_mask;
        in_next.chars[0] = s_char_right;
        in_next.chars[1] = s_char_third;
        in_next.chars[2] = s_char_second;
        in_next.chars[3] = s_char_left;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= in_next;
        end
    end

    // Decimal split of the number, one digit weight per stage.
    sseg_digits u_digits (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (dig_ready),
        .in_req    (in_reg),
        .out_valid (dig_valid),
        .out_ready (frm_ready),
        .out_pipe  (dig_pipe)
    );

    // Glyph encoding and the four-frame output buffer.
    sseg_frames u_frames (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (dig_valid),
        .in_ready    (frm_ready),
        .in_pipe     (dig_pipe),
        .night_mode  (night_mode_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_segments  (m_segments),
        .m_position  (m_position),
        .m_dim       (m_dim),
        .m_bad_input (m_bad_input),
        .m_last      (m_last)
    );

    // Short names for the frame handshake and the closing frame.
    assign frame_take  = m_valid && m_ready;
    assign last_frame  = m_valid && m_last;
    assign last_pos_ok = m_position == 2'd3 || m_position == 2'd0;

    // After a frame other than the closing one is taken, the buffer still holds a valid frame of the item.
    `SSEG_ASSERT_NEXT(a_no_gap, aclk, aresetn, frame_take && !m_last, m_valid, "item cut short")

    // The closing frame drives either the thousands position or, when mirrored, the units.
    `SSEG_ASSERT_IMPL(a_last_pos, aclk, aresetn, last_frame, last_pos_ok, "bad last position")

    // After a closing frame the next frame shown opens a new item.
    `SSEG_ASSERT_NEXT(a_new_item, aclk, aresetn, frame_take && m_last, !last_frame, "double last")

endmodule

FILE: sv/sseg_digits.sv
// Three-stage decimal split of the saturated number: thousands, hundreds, tens/units.
// Depends on sseg_pkg.
module sseg_digits (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sseg_pkg::req_t  in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output sseg_pkg::pipe_t out_pipe
);

    logic            a_valid_reg, b_valid_reg, c_valid_reg;
    logic            a_ready, b_ready, c_ready;
    sseg_pkg::pipe_t a_reg, b_reg, c_reg;
    sseg_pkg::pipe_t a_next, b_next, c_next;
    logic [13:0]     sat;
    sseg_pkg::dec_t  dec_a, dec_b, dec_c;

    // Each stage takes a new item when it is empty or its content moves on.
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        sat = (in_req.number > sseg_pkg::NUMBER_MAX) ? sseg_pkg::NUMBER_MAX : in_req.number;
        dec_a = sseg_pkg::dec_step(sat, sseg_pkg::WEIGHT_THOUSANDS);
        a_next           = '0;
        a_next.op        = in_req.op;
        a_next.dots      = in_req.dots;
        a_next.chars     = in_req.chars;
        a_next.over      = in_req.number > sseg_pkg::NUMBER_MAX;
        a_next.digits[3] = dec_a.digit;
        a_next.rem       = 10'(dec_a.rem);
    end

    always_comb begin
        dec_b = sseg_pkg::dec_step(14'(a_reg.rem), sseg_pkg::WEIGHT_HUNDREDS);
        b_next           = a_reg;
        b_next.digits[2] = dec_b.digit;
        b_next.rem       = 10'(dec_b.rem);
    end

    always_comb begin
        dec_c = sseg_pkg::dec_step(14'(b_reg.rem), sseg_pkg::WEIGHT_TENS);
        c_next           = b_reg;
        c_next.digits[1] = dec_c.digit;
        c_next.digits[0] = 4'(dec_c.rem);
        c_next.rem       = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_reg <= a_next;
        end
        if (a_valid_reg && b_ready) begin
            b_reg <= b_next;
        end
        if (b_valid_reg && c_ready) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_pipe  = c_reg;

endmodule

FILE: sv/sseg_frames.sv
// Glyph encoding of one request into four frames and the frame sequencer on the output side.
// Depends on sseg_pkg.
module sseg_frames (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sseg_pkg::pipe_t in_pipe,
    input  logic            night_mode,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_segments,
    output logic [1:0]      m_position,
    output logic            m_dim,
    output logic            m_bad_input,
    output logic            m_last
);

    logic            valid_reg, valid_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [3:0][7:0] seg_reg, seg_next;
    logic            mirror_reg, mirror_next;
    logic            bad_reg, bad_next;
    logic [3:0]      lead;
    logic            load;
    logic            frame_done;

    // Leading zeros blank; the units digit always shows.
    always_comb begin
        lead[3] = in_pipe.digits[3] == 4'd0;
        lead[2] = lead[3] && in_pipe.digits[2] == 4'd0;
        lead[1] = lead[2] && in_pipe.digits[1] == 4'd0;
        lead[0] = 1'b0;
    end

    always_comb begin
        logic [7:0]      g;
        sseg_pkg::char_t cg;
        seg_next    = '0;
        bad_next    = 1'b0;
        mirror_next = in_pipe.op == sseg_pkg::OP_FLIPPED;
        for (int k = 0; k < 4; k++) begin
            g  = 8'h00;
            cg = sseg_pkg::char_glyph(in_pipe.chars[k]);
            case (in_pipe.op)
                sseg_pkg::OP_NUMBER, sseg_pkg::OP_FLIPPED: begin
                    g = lead[k] ? 8'h00
                        : sseg_pkg::num_glyph(in_pipe.digits[k], mirror_next);
                    g[7] = in_pipe.dots[k];
                    bad_next = in_pipe.over;
                end
                sseg_pkg::OP_LETTERS: begin
                    g = cg.glyph;
                    bad_next = bad_next | cg.bad;
                end
                default: begin
                    g = 8'h00;
                    bad_next = 1'b1;
                end
            endcase
            seg_next[k] = sseg_pkg::to_pins(g);
        end
    end

    // The buffer refills in the same cycle its fourth frame leaves.
    assign frame_done = valid_reg && m_ready;
    assign in_ready   = !valid_reg || (m_ready && cnt_reg == 2'd3);
    assign load       = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (frame_done) begin
            cnt_next = 2'(cnt_reg + 2'd1);
            if (cnt_reg == 2'd3) begin
                valid_next = 1'b0;
            end
        end
        if (load) begin
            valid_next = 1'b1;
            cnt_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            seg_reg    <= seg_next;
            mirror_reg <= mirror_next;
            bad_reg    <= bad_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_segments  = seg_reg[cnt_reg];
    assign m_position  = mirror_reg ? 2'(2'd3 - cnt_reg) : cnt_reg;
    assign m_dim       = night_mode;
    assign m_bad_input = bad_reg;
    assign m_last      = cnt_reg == 2'd3;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the four-digit seven-segment encoder.
// Depends on sseg_pkg for opcodes and the register address, and on the encoder RTL.
// Each request item is predicted as four display frames and checked in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names three opcodes; the fourth one only makes blank, flagged frames.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] ASCII_SPACE = 8'd32;
    localparam logic [7:0] ASCII_A     = 8'd65;
    localparam logic [7:0] ASCII_Z     = 8'd90;

    localparam logic [13:0] DISPLAY_MAX = 14'd9999;

    // Glyphs in A..G,DP bit order, before they are moved to the shift-register pins.
    localparam logic [7:0] UPRIGHT_DIGIT [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7C, 8'h07, 8'h7F, 8'h67
    };
    localparam logic [7:0] FLIPPED_DIGIT [10] = '{
        8'h3F, 8'h30, 8'h5B, 8'h79, 8'h74, 8'h6D, 8'h67, 8'h38, 8'h7F, 8'h7C
    };
    localparam logic [7:0] LETTER_GLYPH [26] = '{
        8'h77, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h04, 8'h0E, 8'h70,
        8'h38, 8'h23, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h72,
        8'h4F, 8'h76, 8'h66, 8'h49
    };
    localparam logic [7:0] GLYPH_POINT = 8'h80;

    // One display request as it is driven onto the input channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] number;
        logic [3:0]  dots;
        logic [7:0]  left;
        logic [7:0]  second;
        logic [7:0]  third;
        logic [7:0]  right;
    } display_request_t;

    // One digit frame as it should appear on the result channel.
    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] position;
        logic       dim;
        logic       bad_input;
        logic       last;
    } display_frame_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [13:0] s_number;
    logic [3:0]  s_dot_mask;
    logic [7:0]  s_char_left;
    logic [7:0]  s_char_second;
    logic [7:0]  s_char_third;
    logic [7:0]  s_char_right;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_segments;
    logic [1:0]  m_position;
    logic        m_dim;
    logic        m_bad_input;
    logic        m_last;

    // Frames still owed by the block, oldest first.
    display_frame_t expected_frames[$];
    int             mismatch_count = 0;

    // Our own copy of the night mode register, updated when a write completes.
    logic night_mode_copy = 1'b0;

    // Idle switches: when off, that side runs at full rate.
    bit sender_gaps_on     = 1'b1;
    bit receiver_stalls_on = 1'b1;

    four_digit_seven_segment_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_number      (s_number),
        .s_dot_mask    (s_dot_mask),
        .s_char_left   (s_char_left),
        .s_char_second (s_char_second),
        .s_char_third  (s_char_third),
        .s_char_right  (s_char_right),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_segments    (m_segments),
        .m_position    (m_position),
        .m_dim         (m_dim),
        .m_bad_input   (m_bad_input),
        .m_last        (m_last)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Move glyph bits A,B,C,D,E,F,G,DP onto pins Q0,Q2,Q6,Q4,Q3,Q1,Q7,Q5.
    function automatic logic [7:0] glyph_to_pins(input logic [7:0] g);
        logic [7:0] pins;
        pins    = '0;
        pins[0] = g[0];
        pins[2] = g[1];
        pins[6] = g[2];
        pins[4] = g[3];
        pins[3] = g[4];
        pins[1] = g[5];
        pins[7] = g[6];
        pins[5] = g[7];
        return pins;
    endfunction

    // Work out the four frames of one request and queue them units first.
    function automatic void predict_frames(input display_request_t req);
        logic [7:0]     glyph [4];
        logic [1:0]     where [4];
        logic [7:0]     letter [4];
        int             digit [4];
        int             value;
        logic           flagged;
        logic           leading;
        display_frame_t frame;

        flagged = 1'b0;
        if (req.op == sseg_pkg::OP_NUMBER || req.op == sseg_pkg::OP_FLIPPED) begin
            value = int'(req.number);
            if (req.number > DISPLAY_MAX) begin
                value   = int'(DISPLAY_MAX);
                flagged = 1'b1;
            end
            digit[3] = value / 1000;
            digit[2] = (value / 100) % 10;
            digit[1] = (value / 10) % 10;
            digit[0] = value % 10;
            // Zeros above the first nonzero digit go dark; the units digit always shows.
            leading = 1'b1;
            for (int k = 3; k >= 0; k--) begin
                if (k == 0 || digit[k] != 0) begin
                    leading = 1'b0;
                end
                if (leading) begin
                    glyph[k] = 8'h00;
                end else if (req.op == sseg_pkg::OP_NUMBER) begin
                    glyph[k] = UPRIGHT_DIGIT[digit[k]];
                end else begin
                    glyph[k] = FLIPPED_DIGIT[digit[k]];
                end
                if (req.dots[k]) begin
                    glyph[k] = glyph[k] | GLYPH_POINT;
                end
                where[k] = (req.op == sseg_pkg::OP_NUMBER) ? 2'(k) : 2'(3 - k);
            end
        end else if (req.op == sseg_pkg::OP_LETTERS) begin
            letter[0] = req.right;
            letter[1] = req.third;
            letter[2] = req.second;
            letter[3] = req.left;
            for (int k = 0; k < 4; k++) begin
                glyph[k] = 8'h00;
                if (letter[k] >= ASCII_A && letter[k] <= ASCII_Z) begin
                    glyph[k] = LETTER_GLYPH[letter[k] - ASCII_A];
                end else if (letter[k] != ASCII_SPACE) begin
                    flagged = 1'b1;
                end
                where[k] = 2'(k);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                glyph[k] = 8'h00;
                where[k] = 2'(k);
            end
            flagged = 1'b1;
        end

        for (int k = 0; k < 4; k++) begin
            frame.segments  = glyph_to_pins(glyph[k]);
            frame.position  = where[k];
            frame.dim       = night_mode_copy;
            frame.bad_input = flagged;
            frame.last      = (k == 3);
            expected_frames.push_back(frame);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking: every frame taken at a rising edge is compared with the oldest expectation.
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : frame_check
        display_frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("frame arrived with no request outstanding: segments %0h position %0d",
                       m_segments, m_position);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                compare_field("segments", want.segments, m_segments);
                compare_field("position", want.position, m_position);
                compare_field("dim", want.dim, m_dim);
                compare_field("bad_input", want.bad_input, m_bad_input);
                compare_field("last", want.last, m_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: before each frame it holds ready low for a random number of cycles.
    // Ready changes only at falling edges, one assignment per edge.
    // ------------------------------------------------------------------

    initial begin : frame_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = receiver_stalls_on ? $urandom_range(0, 7) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready = 1'b0;
            end
            @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Send one request item. With no gap drawn, valid stays high from the previous
    // item and only the payload changes at the next falling edge.
    task automatic send_request(input display_request_t req);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid       = 1'b1;
        s_op          = req.op;
        s_number      = req.number;
        s_dot_mask    = req.dots;
        s_char_left   = req.left;
        s_char_second = req.second;
        s_char_third  = req.third;
        s_char_right  = req.right;
        do @(posedge aclk); while (!s_ready);
        predict_frames(req);
    endtask

    // Lower valid and wait until every owed frame is back, then give the
    // pipeline time to settle before anything else happens.
    task automatic drain_frames();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle; it lands when pready is high.
    task automatic write_night_mode(input logic setting);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = sseg_pkg::ADDR_NIGHT_MODE;
        pwdata  = {31'd0, setting};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        night_mode_copy = setting;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic display_request_t make_request(input logic [1:0] op,
                                                      input logic [13:0] number,
                                                      input logic [3:0] dots,
                                                      input logic [7:0] left,
                                                      input logic [7:0] second,
                                                      input logic [7:0] third,
                                                      input logic [7:0] right);
        display_request_t req;
        req.op     = op;
        req.number = number;
        req.dots   = dots;
        req.left   = left;
        req.second = second;
        req.third  = third;
        req.right  = right;
        return req;
    endfunction

    // Mostly a letter or a space, now and then any byte at all.
    function automatic logic [7:0] random_char();
        int pick;
        if ($urandom_range(0, 9) < 8) begin
            pick = $urandom_range(0, 26);
            return (pick == 26) ? ASCII_SPACE : 8'(ASCII_A + pick);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Numbers are spread over digit counts so that blanking of leading zeros
    // is hit often; a share lies above the display range.
    function automatic logic [13:0] random_number();
        case ($urandom_range(0, 9))
            0, 1:    return 14'($urandom_range(0, 9));
            2:       return 14'($urandom_range(10, 99));
            3:       return 14'($urandom_range(100, 999));
            8:       return 14'($urandom_range(10000, 16383));
            9:       return 14'($urandom_range(0, 16383));
            default: return 14'($urandom_range(1000, 9999));
        endcase
    endfunction

    function automatic display_request_t random_request();
        display_request_t req;
        int               pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            req.op = sseg_pkg::OP_NUMBER;
        end else if (pick < 13) begin
            req.op = sseg_pkg::OP_FLIPPED;
        end else if (pick < 19) begin
            req.op = sseg_pkg::OP_LETTERS;
        end else begin
            req.op = OP_UNUSED;
        end
        // Fields the op ignores still carry random values.
        req.number = random_number();
        req.dots   = 4'($urandom_range(0, 15));
        req.left   = random_char();
        req.second = random_char();
        req.third  = random_char();
        req.right  = random_char();
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Upright numbers: every digit count, the edges of the range, saturation,
    // and decimal points both on blanked and on lit digits.
    task automatic test_upright_numbers();
        write_night_mode(1'b0);
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd0, 4'h0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd7, 4'h1,
                                  8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd10, 4'h2,
                                  8'h41, 8'h20, 8'h00, 8'h7F));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd99, 4'h4,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd100, 4'h8,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd999, 4'hF,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd1000, 4'h0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd9999, 4'hF,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd10000, 4'h5,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd16383, 4'hA,
                                  8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Upside-down numbers land on mirrored positions with their own glyph set.
    task automatic test_flipped_numbers();
        send_request(make_request(sseg_pkg::OP_FLIPPED, 14'd0, 4'hF,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_FLIPPED, 14'd56, 4'h0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_FLIPPED, 14'd1234, 4'h0,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_FLIPPED, 14'd9999, 4'h5,
                                  8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_FLIPPED, 14'd16383, 4'hA,
                                  8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Letters: both ends of the alphabet, all spaces, codes just outside the
    // alphabet, lower case, and the byte extremes.
    task automatic test_letters();
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd16383, 4'hF, "A", "B", "Y", "Z"));
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd0, 4'h0, " ", " ", " ", " "));
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd0, 4'h0, "A", 8'd64, 8'd91, "Z"));
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd0, 4'h0, 8'h00, 8'hFF, " ", "M"));
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd0, 4'h0, "a", "N", 8'd31, 8'd33));
    endtask

    // The unused opcode gives four blank, flagged frames whatever the fields hold.
    task automatic test_unused_op();
        send_request(make_request(OP_UNUSED, 14'd1234, 4'hF, "H", "E", "L", "P"));
    endtask

    // Night mode must reach the dim flag of every frame; it is written only
    // once the block has gone quiet.
    task automatic test_night_mode();
        drain_frames();
        write_night_mode(1'b1);
        send_request(make_request(sseg_pkg::OP_NUMBER, 14'd8, 4'h1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_request(sseg_pkg::OP_LETTERS, 14'd0, 4'h0, "D", "I", "M", " "));
        drain_frames();
        write_night_mode(1'b0);
    endtask

    // Random requests in phases. Each phase sets night mode and the idle
    // pattern of both sides; between phases the sender holds off until all
    // owed frames have come back.
    task automatic test_random_requests();
        logic phase_night [6]     = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        bit   phase_gaps [6]      = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        bit   phase_stalls [6]    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int phase = 0; phase < 6; phase++) begin
            drain_frames();
            write_night_mode(phase_night[phase]);
            sender_gaps_on     = phase_gaps[phase];
            receiver_stalls_on = phase_stalls[phase];
            repeat (41) send_request(random_request());
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_op          = sseg_pkg::OP_NUMBER;
        s_number      = '0;
        s_dot_mask    = '0;
        s_char_left   = '0;
        s_char_second = '0;
        s_char_third  = '0;
        s_char_right  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_upright_numbers();
        test_flipped_numbers();
        test_letters();
        test_unused_op();
        test_night_mode();
        test_random_requests();

        // Everything has been sent: wait for the last frames and a short tail.
        drain_frames();

        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far sooner than this.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
